// File: hw/rtl/dtf_pkg.sv
// ----------------------------------------------------------------------------
// dtf_pkg
// Shared types and constants for the datetime days/ticks to fields decoder:
// pipeline depth, range limits, exact reciprocal constants and the
// month start table.
// ----------------------------------------------------------------------------
package dtf_pkg;

   localparam int STAGES = 7;

   // day count limits: 1753-01-01 .. 9999-12-31 relative to 1900-01-01
   localparam logic signed [22:0] DAYS_MIN = -23'sd53690;
   localparam logic signed [22:0] DAYS_MAX = 23'sd2958463;
   // days from 0000-03-01 to 1900-01-01
   localparam logic signed [23:0] SHIFT_1900 = 24'sd693901;

   localparam logic [17:0] ERA_DAYS  = 18'd146097;
   localparam logic [17:0] ERA_LAST  = 18'd146096;
   localparam logic [17:0] CENT_DAYS = 18'd36524;
   localparam logic [17:0] YEAR_DAYS = 18'd365;
   localparam logic [13:0] ERA_YEARS = 14'd400;

   // round-up reciprocals, exact for every operand below 2**n
   // q = (x * m) >> (n + l), m = ceil(2**(n+l) / d), l = ceil(log2(d))
   localparam logic [22:0] ERA_RECIP  = 23'(((64'd1 << 40) + 64'd146096) / 64'd146097);
   localparam int          ERA_SHIFT  = 40;
   localparam logic [18:0] Q1460_RECIP = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
   localparam int          Q1460_SHIFT = 29;
   localparam logic [18:0] Q365_RECIP = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
   localparam int          Q365_SHIFT = 27;
   localparam logic [11:0] Q153_RECIP = 12'(((64'd1 << 19) + 64'd152) / 64'd153);
   localparam int          Q153_SHIFT = 19;
   localparam logic [29:0] Q3_RECIP   = 30'(((64'd1 << 31) + 64'd2) / 64'd3);
   localparam int          Q3_SHIFT   = 31;
   localparam logic [27:0] Q1000_RECIP = 28'(((64'd1 << 37) + 64'd999) / 64'd1000);
   localparam int          Q1000_SHIFT = 37;
   localparam logic [17:0] Q3600_RECIP = 18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
   localparam int          Q3600_SHIFT = 29;
   localparam logic [17:0] Q60_RECIP  = 18'(((64'd1 << 23) + 64'd59) / 64'd60);
   localparam int          Q60_SHIFT  = 23;

   typedef struct packed {
      logic [STAGES-1:0] load;
   } pipe_ctrl_type;

   typedef struct packed {
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day_of_month;
   } date_fields_type;

   typedef struct packed {
      logic [4:0] hours;
      logic [5:0] minutes;
      logic [5:0] seconds;
      logic [9:0] milliseconds;
   } time_fields_type;

   // first day of each month in a march-based year, (153*mp+2)/5
   function automatic logic [8:0] month_start(input logic [3:0] mp);
      logic [8:0] r;
      case (mp)
         4'd0:    r = 9'd0;
         4'd1:    r = 9'd31;
         4'd2:    r = 9'd61;
         4'd3:    r = 9'd92;
         4'd4:    r = 9'd122;
         4'd5:    r = 9'd153;
         4'd6:    r = 9'd184;
         4'd7:    r = 9'd214;
         4'd8:    r = 9'd245;
         4'd9:    r = 9'd275;
         4'd10:   r = 9'd306;
         4'd11:   r = 9'd337;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

endpackage

// File: hw/rtl/dtf_date_path.sv
// ----------------------------------------------------------------------------
// dtf_date_path
// Seven-stage civil date decode: era, day of era, year of era, day of year,
// march-based month, then year, month and day of month.
// ----------------------------------------------------------------------------
module dtf_date_path (
   input  logic                    clock,
   input  dtf_pkg::pipe_ctrl_type  ctrl,
   input  logic signed [22:0]      days_since_epoch,
   output dtf_pkg::date_fields_type date_out
);

   // stage 1
   logic signed [22:0] days_sat;
   logic signed [23:0] z_wide;
   logic [21:0]        s1_z_in, s1_z_ff;
   logic [44:0]        era_prod;
   logic [4:0]         s1_era_in, s1_era_ff;
   // stage 2
   logic [17:0]        s2_doe_in, s2_doe_ff;
   logic [13:0]        s2_ey_in, s2_ey_ff;
   // stage 3
   logic [36:0]        q1460_prod;
   logic [7:0]         q1460;
   logic [2:0]         q_cent;
   logic               q_last;
   logic [17:0]        s3_t_in, s3_t_ff, s3_doe_ff;
   logic [13:0]        s3_ey_ff;
   // stage 4
   logic [36:0]        q365_prod;
   logic [8:0]         s4_yoe_in, s4_yoe_ff;
   logic [17:0]        s4_doe_ff;
   logic [13:0]        s4_ey_ff;
   // stage 5
   logic [1:0]         q_hund;
   logic [17:0]        year_base;
   logic [8:0]         s5_doy_in, s5_doy_ff, s5_yoe_ff;
   logic [13:0]        s5_ey_ff;
   // stage 6
   logic [10:0]        mp_num;
   logic [22:0]        q153_prod;
   logic [3:0]         s6_mp_in, s6_mp_ff;
   logic [8:0]         s6_doy_ff, s6_yoe_ff;
   logic [13:0]        s6_ey_ff;
   // stage 7
   dtf_pkg::date_fields_type date_in, date_ff;

   // saturate, shift to a march 0000 epoch, split off 400-year eras
   always_comb begin
      if (days_since_epoch < dtf_pkg::DAYS_MIN) begin
         days_sat = dtf_pkg::DAYS_MIN;
      end else if (days_since_epoch > dtf_pkg::DAYS_MAX) begin
         days_sat = dtf_pkg::DAYS_MAX;
      end else begin
         days_sat = days_since_epoch;
      end
      z_wide    = 24'(days_sat) + dtf_pkg::SHIFT_1900;
      s1_z_in   = z_wide[21:0];
      era_prod  = 45'(s1_z_in) * 45'(dtf_pkg::ERA_RECIP);
      s1_era_in = era_prod[dtf_pkg::ERA_SHIFT +: 5];
   end

   always_comb begin
      s2_doe_in = 18'(s1_z_ff - 22'(22'(s1_era_ff) * 22'(dtf_pkg::ERA_DAYS)));
      s2_ey_in  = 14'(s1_era_ff) * dtf_pkg::ERA_YEARS;
   end

   // leap day corrections before the divide by 365
   always_comb begin
      q1460_prod = 37'(s2_doe_ff) * 37'(dtf_pkg::Q1460_RECIP);
      q1460      = q1460_prod[dtf_pkg::Q1460_SHIFT +: 8];
      q_cent     = 3'(s2_doe_ff >= dtf_pkg::CENT_DAYS)
                 + 3'(s2_doe_ff >= 18'(2 * dtf_pkg::CENT_DAYS))
                 + 3'(s2_doe_ff >= 18'(3 * dtf_pkg::CENT_DAYS))
                 + 3'(s2_doe_ff >= dtf_pkg::ERA_LAST);
      q_last     = (s2_doe_ff == dtf_pkg::ERA_LAST);
      s3_t_in    = s2_doe_ff - 18'(q1460) + 18'(q_cent) - 18'(q_last);
   end

   always_comb begin
      q365_prod = 37'(s3_t_ff) * 37'(dtf_pkg::Q365_RECIP);
      s4_yoe_in = q365_prod[dtf_pkg::Q365_SHIFT +: 9];
   end

   always_comb begin
      q_hund    = 2'(s4_yoe_ff >= 9'd100) + 2'(s4_yoe_ff >= 9'd200)
                + 2'(s4_yoe_ff >= 9'd300);
      year_base = 18'(s4_yoe_ff) * dtf_pkg::YEAR_DAYS + 18'(s4_yoe_ff >> 2) - 18'(q_hund);
      s5_doy_in = 9'(s4_doe_ff - year_base);
   end

   always_comb begin
      mp_num    = 11'({s5_doy_ff, 2'b00}) + 11'(s5_doy_ff) + 11'd2;
      q153_prod = 23'(mp_num) * 23'(dtf_pkg::Q153_RECIP);
      s6_mp_in  = q153_prod[dtf_pkg::Q153_SHIFT +: 4];
   end

   always_comb begin
      date_in.day_of_month = 5'(s6_doy_ff - dtf_pkg::month_start(s6_mp_ff) + 9'd1);
      if (s6_mp_ff < 4'd10) begin
         date_in.month = s6_mp_ff + 4'd3;
      end else begin
         date_in.month = s6_mp_ff - 4'd9;
      end
      // january and february belong to the next civil year
      date_in.year = 14'(s6_yoe_ff) + s6_ey_ff + 14'(date_in.month <= 4'd2);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         s1_z_ff   <= s1_z_in;
         s1_era_ff <= s1_era_in;
      end
      if (ctrl.load[1]) begin
         s2_doe_ff <= s2_doe_in;
         s2_ey_ff  <= s2_ey_in;
      end
      if (ctrl.load[2]) begin
         s3_t_ff   <= s3_t_in;
         s3_doe_ff <= s2_doe_ff;
         s3_ey_ff  <= s2_ey_ff;
      end
      if (ctrl.load[3]) begin
         s4_yoe_ff <= s4_yoe_in;
         s4_doe_ff <= s3_doe_ff;
         s4_ey_ff  <= s3_ey_ff;
      end
      if (ctrl.load[4]) begin
         s5_doy_ff <= s5_doy_in;
         s5_yoe_ff <= s4_yoe_ff;
         s5_ey_ff  <= s4_ey_ff;
      end
      if (ctrl.load[5]) begin
         s6_mp_ff  <= s6_mp_in;
         s6_doy_ff <= s5_doy_ff;
         s6_yoe_ff <= s5_yoe_ff;
         s6_ey_ff  <= s5_ey_ff;
      end
      if (ctrl.load[6]) begin
         date_ff <= date_in;
      end
   end

   assign date_out = date_ff;

endmodule

// File: hw/rtl/dtf_time_path.sv
// ----------------------------------------------------------------------------
// dtf_time_path
// Time of day decode: ticks to milliseconds, then seconds, hours and
// minutes; results ride along to line up with the date path.
// ----------------------------------------------------------------------------
module dtf_time_path (
   input  logic                     clock,
   input  dtf_pkg::pipe_ctrl_type   ctrl,
   input  logic [24:0]              ticks_since_midnight,
   output dtf_pkg::time_fields_type time_out
);

   logic [28:0] ms_num;
   logic [58:0] q3_prod;
   logic [26:0] s1_ms_in, s1_ms_ff;
   logic [54:0] q1000_prod;
   logic [16:0] s2_secs_in, s2_secs_ff;
   logic [26:0] s2_ms_ff;
   logic [34:0] q3600_prod, q60_prod;
   logic [9:0]  s3_msr_in, s3_msr_ff;
   logic [4:0]  s3_hq_in, s3_hq_ff;
   logic [10:0] s3_q60_in, s3_q60_ff;
   logic [16:0] s3_secs_ff;
   dtf_pkg::time_fields_type s4_in, s4_ff, s5_ff, s6_ff, s7_ff;

   // ms = (10 * ticks + 1) / 3
   always_comb begin
      ms_num   = 29'({ticks_since_midnight, 3'b000}) + 29'({ticks_since_midnight, 1'b0})
               + 29'd1;
      q3_prod  = 59'(ms_num) * 59'(dtf_pkg::Q3_RECIP);
      s1_ms_in = q3_prod[dtf_pkg::Q3_SHIFT +: 27];
   end

   always_comb begin
      q1000_prod = 55'(s1_ms_ff) * 55'(dtf_pkg::Q1000_RECIP);
      s2_secs_in = q1000_prod[dtf_pkg::Q1000_SHIFT +: 17];
   end

   // whole minutes and whole hours both come straight from seconds
   always_comb begin
      s3_msr_in  = 10'(s2_ms_ff - 27'(27'(s2_secs_ff) * 27'd1000));
      q3600_prod = 35'(s2_secs_ff) * 35'(dtf_pkg::Q3600_RECIP);
      s3_hq_in   = q3600_prod[dtf_pkg::Q3600_SHIFT +: 5];
      q60_prod   = 35'(s2_secs_ff) * 35'(dtf_pkg::Q60_RECIP);
      s3_q60_in  = q60_prod[dtf_pkg::Q60_SHIFT +: 11];
   end

   always_comb begin
      // ticks past one day reach at most 31 hours
      if (s3_hq_ff >= 5'd24) begin
         s4_in.hours = s3_hq_ff - 5'd24;
      end else begin
         s4_in.hours = s3_hq_ff;
      end
      s4_in.minutes      = 6'(s3_q60_ff - 11'(11'(s3_hq_ff) * 11'd60));
      s4_in.seconds      = 6'(s3_secs_ff - 17'(17'(s3_q60_ff) * 17'd60));
      s4_in.milliseconds = s3_msr_ff;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         s1_ms_ff <= s1_ms_in;
      end
      if (ctrl.load[1]) begin
         s2_secs_ff <= s2_secs_in;
         s2_ms_ff   <= s1_ms_ff;
      end
      if (ctrl.load[2]) begin
         s3_msr_ff  <= s3_msr_in;
         s3_hq_ff   <= s3_hq_in;
         s3_q60_ff  <= s3_q60_in;
         s3_secs_ff <= s2_secs_ff;
      end
      if (ctrl.load[3]) begin
         s4_ff <= s4_in;
      end
      if (ctrl.load[4]) begin
         s5_ff <= s4_ff;
      end
      if (ctrl.load[5]) begin
         s6_ff <= s5_ff;
      end
      if (ctrl.load[6]) begin
         s7_ff <= s6_ff;
      end
   end

   assign time_out = s7_ff;

endmodule

// File: hw/rtl/datetime_days_ticks_to_fields_unit.sv
// ----------------------------------------------------------------------------
// datetime_days_ticks_to_fields_unit
// Decodes a day count from 1900-01-01 and 1/300 s ticks into calendar date
// and time of day fields.
// ----------------------------------------------------------------------------
// The unit takes one request per clock while req_stall is low; each
// request passes through the seven register stages of the date path.
// Each stage has its own valid bit and loads whenever it is empty or the
// next stage moves, so bubbles are squeezed out and a stalled result does
// not block requests until every stage is full. Day counts outside
// 1753-01-01 .. 9999-12-31 are clamped to the nearer end; tick counts
// past one day carry into the time fields with hours wrapping modulo 24.
module datetime_days_ticks_to_fields_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [22:0] req_days_since_epoch,
   input  logic [24:0]        req_ticks_since_midnight,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [13:0]        rsp_year,
   output logic [3:0]         rsp_month,
   output logic [4:0]         rsp_day_of_month,
   output logic [4:0]         rsp_hours,
   output logic [5:0]         rsp_minutes,
   output logic [5:0]         rsp_seconds,
   output logic [9:0]         rsp_milliseconds
);

   logic [dtf_pkg::STAGES-1:0] valid_in, valid_ff, ready;
   dtf_pkg::pipe_ctrl_type     ctrl;
   dtf_pkg::date_fields_type   date_out;
   dtf_pkg::time_fields_type   time_out;

   always_comb begin
      ready[dtf_pkg::STAGES-1] = !valid_ff[dtf_pkg::STAGES-1] || !rsp_stall;
      for (int k = dtf_pkg::STAGES - 2; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
      valid_in[0] = ready[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < dtf_pkg::STAGES; k++) begin
         valid_in[k] = ready[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   assign ctrl.load = ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   dtf_date_path u_date (
      .clock            (clock),
      .ctrl             (ctrl),
      .days_since_epoch (req_days_since_epoch),
      .date_out         (date_out)
   );

   dtf_time_path u_time (
      .clock                (clock),
      .ctrl                 (ctrl),
      .ticks_since_midnight (req_ticks_since_midnight),
      .time_out             (time_out)
   );

   assign req_stall        = !ready[0];
   assign rsp_valid        = valid_ff[dtf_pkg::STAGES-1];
   assign rsp_year         = date_out.year;
   assign rsp_month        = date_out.month;
   assign rsp_day_of_month = date_out.day_of_month;
   assign rsp_hours        = time_out.hours;
   assign rsp_minutes      = time_out.minutes;
   assign rsp_seconds      = time_out.seconds;
   assign rsp_milliseconds = time_out.milliseconds;

   // requests in flight change only by what enters and what leaves
   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      !reset |=> $countones(valid_ff) == $past($countones(valid_ff))
                 + $past(int'(req_valid && !req_stall))
                 - $past(int'(rsp_valid && !rsp_stall)))
      else $error("pipeline occupancy mismatch");

   // a full pipeline behind a stalled result must push back
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      ((&valid_ff) && rsp_stall) |-> req_stall)
      else $error("request taken into a full stalled pipeline");

   a_fields_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_month >= 4'd1 && rsp_month <= 4'd12
                     && rsp_day_of_month >= 5'd1 && rsp_hours < 5'd24
                     && rsp_minutes < 6'd60 && rsp_seconds < 6'd60
                     && rsp_milliseconds < 10'd1000))
      else $error("result field out of range");

endmodule
